FILE: sv/qrt_pkg.sv
// Shared types, constants and rounding helpers for the quaternion rigid transform.
`timescale 1ns / 1ps

package qrt_pkg;

    localparam int WordW = 32;
    localparam int QFrac = 30;
    // accumulator holds the exact sum of up to four 65-bit products
    localparam int AccW  = 68;
    // width of the clipped intermediate rotation vector
    localparam int RW    = 33;
    localparam int IdxW  = 3;

    typedef logic signed [WordW-1:0] t_word;
    typedef logic signed [AccW-1:0]  t_acc;
    typedef logic signed [RW-1:0]    t_rcoord;
    typedef logic [IdxW-1:0]         t_reg_idx;

    typedef struct packed {
        t_word w;
        t_word x;
        t_word y;
        t_word z;
    } t_quat;

    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
    } t_vec;

    typedef struct packed {
        t_rcoord x;
        t_rcoord y;
        t_rcoord z;
    } t_rvec;

    typedef struct packed {
        logic valid;
        logic op;
    } t_ctl;

    localparam logic OP_POINT   = 1'b0;
    localparam logic OP_COMPOSE = 1'b1;

    localparam t_reg_idx REG_ROT_W   = 3'd0;
    localparam t_reg_idx REG_ROT_X   = 3'd1;
    localparam t_reg_idx REG_ROT_Y   = 3'd2;
    localparam t_reg_idx REG_ROT_Z   = 3'd3;
    localparam t_reg_idx REG_SHIFT_X = 3'd4;
    localparam t_reg_idx REG_SHIFT_Y = 3'd5;
    localparam t_reg_idx REG_SHIFT_Z = 3'd6;

    localparam t_word ROT_W_RESET = 32'sh4000_0000;

    localparam t_acc R_LIM_HI   = t_acc'(64'sh0000_0000_FFFF_FFFF);
    localparam t_acc R_LIM_LO   = -R_LIM_HI;
    localparam t_acc W32_LIM_HI = t_acc'(64'sh0000_0000_7FFF_FFFF);
    localparam t_acc W32_LIM_LO = -t_acc'(64'sh0000_0000_8000_0000);
    localparam t_acc HALF_LSB   = t_acc'(64'sh0000_0000_2000_0000);

    // round half up of the exact sum, scaled down by 2^30
    function automatic t_acc round_q30(input t_acc a, input t_acc b,
                                       input t_acc c, input t_acc d);
        t_acc s;
        s = a + b + c + d + HALF_LSB;
        return s >>> QFrac;
    endfunction

    function automatic logic out_of(input t_acc x, input t_acc lo, input t_acc hi);
        return (x < lo) || (x > hi);
    endfunction

    function automatic t_acc clip(input t_acc x, input t_acc lo, input t_acc hi);
        t_acc y;
        priority if (x < lo) begin
            y = lo;
        end else if (x > hi) begin
            y = hi;
        end else begin
            y = x;
        end
        return y;
    endfunction

endpackage

FILE: sv/qrt_cfg.sv
// Configuration registers: rotation quaternion and translation.
`timescale 1ns / 1ps

module qrt_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  qrt_pkg::t_reg_idx i_cfg_idx,
    input  qrt_pkg::t_word    i_cfg_data,
    output qrt_pkg::t_quat    o_rot,
    output qrt_pkg::t_vec     o_shift
);

    qrt_pkg::t_quat r_rot;
    qrt_pkg::t_vec  r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot.w   <= qrt_pkg::ROT_W_RESET;
            r_rot.x   <= '0;
            r_rot.y   <= '0;
            r_rot.z   <= '0;
            r_shift   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qrt_pkg::REG_ROT_W:   r_rot.w   <= i_cfg_data;
                qrt_pkg::REG_ROT_X:   r_rot.x   <= i_cfg_data;
                qrt_pkg::REG_ROT_Y:   r_rot.y   <= i_cfg_data;
                qrt_pkg::REG_ROT_Z:   r_rot.z   <= i_cfg_data;
                qrt_pkg::REG_SHIFT_X: r_shift.x <= i_cfg_data;
                qrt_pkg::REG_SHIFT_Y: r_shift.y <= i_cfg_data;
                qrt_pkg::REG_SHIFT_Z: r_shift.z <= i_cfg_data;
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    assign o_rot   = r_rot;
    assign o_shift = r_shift;

endmodule

FILE: sv/qrt_rot1.sv
// First half of the pipeline: v*conj(q) and q*q2 products, then rounding and clipping.
`timescale 1ns / 1ps

module qrt_rot1 (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qrt_pkg::t_ctl  i_ctl,
    input  qrt_pkg::t_quat i_rot,
    input  qrt_pkg::t_quat i_q2,
    input  qrt_pkg::t_vec  i_v,
    output qrt_pkg::t_ctl  o_ctl,
    output qrt_pkg::t_rvec o_r,
    output qrt_pkg::t_quat o_qq,
    output logic           o_sat
);

    // stage 1: products
    qrt_pkg::t_ctl     r_ctl1;
    logic signed [63:0] r_pv [4][3];
    logic signed [63:0] r_pq [4][4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
        end
    end

    // r = v*conj(q), signs of conj folded into the sums below
    always_ff @(posedge i_clk) begin
        r_pv[0][0] <= i_v.x * i_rot.x;
        r_pv[0][1] <= i_v.y * i_rot.y;
        r_pv[0][2] <= i_v.z * i_rot.z;
        r_pv[1][0] <= i_v.x * i_rot.w;
        r_pv[1][1] <= i_v.y * i_rot.z;
        r_pv[1][2] <= i_v.z * i_rot.y;
        r_pv[2][0] <= i_v.y * i_rot.w;
        r_pv[2][1] <= i_v.z * i_rot.x;
        r_pv[2][2] <= i_v.x * i_rot.z;
        r_pv[3][0] <= i_v.z * i_rot.w;
        r_pv[3][1] <= i_v.x * i_rot.y;
        r_pv[3][2] <= i_v.y * i_rot.x;

        r_pq[0][0] <= i_rot.w * i_q2.w;
        r_pq[0][1] <= i_rot.x * i_q2.x;
        r_pq[0][2] <= i_rot.y * i_q2.y;
        r_pq[0][3] <= i_rot.z * i_q2.z;
        r_pq[1][0] <= i_rot.w * i_q2.x;
        r_pq[1][1] <= i_rot.x * i_q2.w;
        r_pq[1][2] <= i_rot.y * i_q2.z;
        r_pq[1][3] <= i_rot.z * i_q2.y;
        r_pq[2][0] <= i_rot.w * i_q2.y;
        r_pq[2][1] <= i_rot.y * i_q2.w;
        r_pq[2][2] <= i_rot.z * i_q2.x;
        r_pq[2][3] <= i_rot.x * i_q2.z;
        r_pq[3][0] <= i_rot.w * i_q2.z;
        r_pq[3][1] <= i_rot.x * i_q2.y;
        r_pq[3][2] <= i_rot.z * i_q2.w;
        r_pq[3][3] <= i_rot.y * i_q2.x;
    end

    // stage 2: sum, round, clip
    qrt_pkg::t_acc n_r0, n_r1, n_r2, n_r3;
    qrt_pkg::t_acc n_qw, n_qx, n_qy, n_qz;
    qrt_pkg::t_acc n_r1_c, n_r2_c, n_r3_c;
    qrt_pkg::t_acc n_qw_c, n_qx_c, n_qy_c, n_qz_c;
    logic          n_sat_r, n_sat_q, n_sat;

    assign n_r0 = qrt_pkg::round_q30(qrt_pkg::t_acc'(r_pv[0][0]),
        qrt_pkg::t_acc'(r_pv[0][1]), qrt_pkg::t_acc'(r_pv[0][2]), '0);
    assign n_r1 = qrt_pkg::round_q30(qrt_pkg::t_acc'(r_pv[1][0]),
        -qrt_pkg::t_acc'(r_pv[1][1]), qrt_pkg::t_acc'(r_pv[1][2]), '0);
    assign n_r2 = qrt_pkg::round_q30(qrt_pkg::t_acc'(r_pv[2][0]),
        -qrt_pkg::t_acc'(r_pv[2][1]), qrt_pkg::t_acc'(r_pv[2][2]), '0);
    assign n_r3 = qrt_pkg::round_q30(qrt_pkg::t_acc'(r_pv[3][0]),
        -qrt_pkg::t_acc'(r_pv[3][1]), qrt_pkg::t_acc'(r_pv[3][2]), '0);

    assign n_qw = qrt_pkg::round_q30(qrt_pkg::t_acc'(r_pq[0][0]),
        -qrt_pkg::t_acc'(r_pq[0][1]), -qrt_pkg::t_acc'(r_pq[0][2]),
        -qrt_pkg::t_acc'(r_pq[0][3]));
    assign n_qx = qrt_pkg::round_q30(qrt_pkg::t_acc'(r_pq[1][0]),
        qrt_pkg::t_acc'(r_pq[1][1]), qrt_pkg::t_acc'(r_pq[1][2]),
        -qrt_pkg::t_acc'(r_pq[1][3]));
    assign n_qy = qrt_pkg::round_q30(qrt_pkg::t_acc'(r_pq[2][0]),
        qrt_pkg::t_acc'(r_pq[2][1]), qrt_pkg::t_acc'(r_pq[2][2]),
        -qrt_pkg::t_acc'(r_pq[2][3]));
    assign n_qz = qrt_pkg::round_q30(qrt_pkg::t_acc'(r_pq[3][0]),
        qrt_pkg::t_acc'(r_pq[3][1]), qrt_pkg::t_acc'(r_pq[3][2]),
        -qrt_pkg::t_acc'(r_pq[3][3]));

    assign n_r1_c = qrt_pkg::clip(n_r1, qrt_pkg::R_LIM_LO, qrt_pkg::R_LIM_HI);
    assign n_r2_c = qrt_pkg::clip(n_r2, qrt_pkg::R_LIM_LO, qrt_pkg::R_LIM_HI);
    assign n_r3_c = qrt_pkg::clip(n_r3, qrt_pkg::R_LIM_LO, qrt_pkg::R_LIM_HI);
    assign n_qw_c = qrt_pkg::clip(n_qw, qrt_pkg::W32_LIM_LO, qrt_pkg::W32_LIM_HI);
    assign n_qx_c = qrt_pkg::clip(n_qx, qrt_pkg::W32_LIM_LO, qrt_pkg::W32_LIM_HI);
    assign n_qy_c = qrt_pkg::clip(n_qy, qrt_pkg::W32_LIM_LO, qrt_pkg::W32_LIM_HI);
    assign n_qz_c = qrt_pkg::clip(n_qz, qrt_pkg::W32_LIM_LO, qrt_pkg::W32_LIM_HI);

    // scalar part of r is dropped later but its clip still counts
    assign n_sat_r = qrt_pkg::out_of(n_r0, qrt_pkg::R_LIM_LO, qrt_pkg::R_LIM_HI)
                   | qrt_pkg::out_of(n_r1, qrt_pkg::R_LIM_LO, qrt_pkg::R_LIM_HI)
                   | qrt_pkg::out_of(n_r2, qrt_pkg::R_LIM_LO, qrt_pkg::R_LIM_HI)
                   | qrt_pkg::out_of(n_r3, qrt_pkg::R_LIM_LO, qrt_pkg::R_LIM_HI);
    assign n_sat_q = qrt_pkg::out_of(n_qw, qrt_pkg::W32_LIM_LO, qrt_pkg::W32_LIM_HI)
                   | qrt_pkg::out_of(n_qx, qrt_pkg::W32_LIM_LO, qrt_pkg::W32_LIM_HI)
                   | qrt_pkg::out_of(n_qy, qrt_pkg::W32_LIM_LO, qrt_pkg::W32_LIM_HI)
                   | qrt_pkg::out_of(n_qz, qrt_pkg::W32_LIM_LO, qrt_pkg::W32_LIM_HI);
    assign n_sat = n_sat_r | ((r_ctl1.op == qrt_pkg::OP_COMPOSE) & n_sat_q);

    qrt_pkg::t_ctl  r_ctl2;
    qrt_pkg::t_rvec r_r;
    qrt_pkg::t_quat r_qq;
    logic           r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else begin
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r.x  <= n_r1_c[qrt_pkg::RW-1:0];
        r_r.y  <= n_r2_c[qrt_pkg::RW-1:0];
        r_r.z  <= n_r3_c[qrt_pkg::RW-1:0];
        r_qq.w <= n_qw_c[qrt_pkg::WordW-1:0];
        r_qq.x <= n_qx_c[qrt_pkg::WordW-1:0];
        r_qq.y <= n_qy_c[qrt_pkg::WordW-1:0];
        r_qq.z <= n_qz_c[qrt_pkg::WordW-1:0];
        r_sat  <= n_sat;
    end

    assign o_ctl = r_ctl2;
    assign o_r   = r_r;
    assign o_qq  = r_qq;
    assign o_sat = r_sat;

endmodule

FILE: sv/qrt_rot2.sv
// Second half of the pipeline: q*r products, rounding, translation and final clip.
`timescale 1ns / 1ps

module qrt_rot2 (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qrt_pkg::t_ctl  i_ctl,
    input  qrt_pkg::t_quat i_rot,
    input  qrt_pkg::t_vec  i_shift,
    input  qrt_pkg::t_rvec i_r,
    input  qrt_pkg::t_quat i_qq,
    input  logic           i_sat,
    output logic           o_valid,
    output qrt_pkg::t_quat o_quat,
    output qrt_pkg::t_vec  o_vec,
    output logic           o_sat
);

    // stage 3: products of q with the pure vector r
    qrt_pkg::t_ctl      r_ctl3;
    logic signed [64:0] r_pw [3][3];
    qrt_pkg::t_quat     r_qq;
    logic               r_sat3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
        end else begin
            r_ctl3 <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pw[0][0] <= i_rot.w * i_r.x;
        r_pw[0][1] <= i_rot.y * i_r.z;
        r_pw[0][2] <= i_rot.z * i_r.y;
        r_pw[1][0] <= i_rot.w * i_r.y;
        r_pw[1][1] <= i_rot.z * i_r.x;
        r_pw[1][2] <= i_rot.x * i_r.z;
        r_pw[2][0] <= i_rot.w * i_r.z;
        r_pw[2][1] <= i_rot.x * i_r.y;
        r_pw[2][2] <= i_rot.y * i_r.x;
        r_qq       <= i_qq;
        r_sat3     <= i_sat;
    end

    // stage 4: round, translate, clip
    qrt_pkg::t_acc n_w1, n_w2, n_w3;
    qrt_pkg::t_acc n_o1, n_o2, n_o3;
    qrt_pkg::t_acc n_o1_c, n_o2_c, n_o3_c;
    logic          n_sat;
    logic          n_compose;

    assign n_w1 = qrt_pkg::round_q30(qrt_pkg::t_acc'(r_pw[0][0]),
        qrt_pkg::t_acc'(r_pw[0][1]), -qrt_pkg::t_acc'(r_pw[0][2]), '0);
    assign n_w2 = qrt_pkg::round_q30(qrt_pkg::t_acc'(r_pw[1][0]),
        qrt_pkg::t_acc'(r_pw[1][1]), -qrt_pkg::t_acc'(r_pw[1][2]), '0);
    assign n_w3 = qrt_pkg::round_q30(qrt_pkg::t_acc'(r_pw[2][0]),
        qrt_pkg::t_acc'(r_pw[2][1]), -qrt_pkg::t_acc'(r_pw[2][2]), '0);

    assign n_o1 = n_w1 + qrt_pkg::t_acc'(i_shift.x);
    assign n_o2 = n_w2 + qrt_pkg::t_acc'(i_shift.y);
    assign n_o3 = n_w3 + qrt_pkg::t_acc'(i_shift.z);

    assign n_o1_c = qrt_pkg::clip(n_o1, qrt_pkg::W32_LIM_LO, qrt_pkg::W32_LIM_HI);
    assign n_o2_c = qrt_pkg::clip(n_o2, qrt_pkg::W32_LIM_LO, qrt_pkg::W32_LIM_HI);
    assign n_o3_c = qrt_pkg::clip(n_o3, qrt_pkg::W32_LIM_LO, qrt_pkg::W32_LIM_HI);

    assign n_sat = r_sat3
                 | qrt_pkg::out_of(n_o1, qrt_pkg::W32_LIM_LO, qrt_pkg::W32_LIM_HI)
                 | qrt_pkg::out_of(n_o2, qrt_pkg::W32_LIM_LO, qrt_pkg::W32_LIM_HI)
                 | qrt_pkg::out_of(n_o3, qrt_pkg::W32_LIM_LO, qrt_pkg::W32_LIM_HI);

    assign n_compose = (r_ctl3.op == qrt_pkg::OP_COMPOSE);

    logic           r_valid;
    qrt_pkg::t_quat r_quat;
    qrt_pkg::t_vec  r_vec;
    logic           r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_ctl3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quat  <= n_compose ? r_qq : '0;
        r_vec.x <= n_o1_c[qrt_pkg::WordW-1:0];
        r_vec.y <= n_o2_c[qrt_pkg::WordW-1:0];
        r_vec.z <= n_o3_c[qrt_pkg::WordW-1:0];
        r_sat   <= n_sat;
    end

    assign o_valid = r_valid;
    assign o_quat  = r_quat;
    assign o_vec   = r_vec;
    assign o_sat   = r_sat;

endmodule

FILE: sv/quaternion_rigid_transform.sv
// Top level of the quaternion rigid transform pipeline.
// Usage:
//   Write rot_w..rot_z (Q1.30) and shift_x..shift_z through i_cfg_we/i_cfg_idx/
//   i_cfg_data while no word is in flight; index 7 is ignored.
//   Present a word on i_operation and the input ports with start high; it is
//   taken at any rising edge where busy is low. Operation 0 rotates and
//   translates a point, operation 1 composes the configured transform with
//   the incoming one.
//   Output: the result sits on the o_ ports, with o_valid high for a single
//   cycle, once the word has passed through the four register stages.
//   Throughput: one word per clock while busy is low; four register stages
//   (two multiply stages, two sum/round/clip stages) run back to back.
//   Reset: synchronous, active low; configuration returns to the identity
//   transform, the pipeline empties and busy stays high until r_run is set.
//   The output has no back-pressure: each result appears exactly once.
`timescale 1ns / 1ps

module quaternion_rigid_transform (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_operation,
    input  logic signed [31:0] i_in_qw,
    input  logic signed [31:0] i_in_qx,
    input  logic signed [31:0] i_in_qy,
    input  logic signed [31:0] i_in_qz,
    input  logic signed [31:0] i_in_x,
    input  logic signed [31:0] i_in_y,
    input  logic signed [31:0] i_in_z,
    output logic        o_valid,
    output logic signed [31:0] o_out_qw,
    output logic signed [31:0] o_out_qx,
    output logic signed [31:0] o_out_qy,
    output logic signed [31:0] o_out_qz,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic        o_saturated
);

    logic r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign busy = ~r_run;

    qrt_pkg::t_quat rot;
    qrt_pkg::t_vec  shift;

    qrt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_rot      (rot),
        .o_shift    (shift)
    );

    qrt_pkg::t_ctl  in_ctl;
    qrt_pkg::t_quat in_q2;
    qrt_pkg::t_vec  in_v;

    assign in_ctl.valid = start & ~busy;
    assign in_ctl.op    = i_operation;
    assign in_q2.w      = i_in_qw;
    assign in_q2.x      = i_in_qx;
    assign in_q2.y      = i_in_qy;
    assign in_q2.z      = i_in_qz;
    assign in_v.x       = i_in_x;
    assign in_v.y       = i_in_y;
    assign in_v.z       = i_in_z;

    qrt_pkg::t_ctl  mid_ctl;
    qrt_pkg::t_rvec mid_r;
    qrt_pkg::t_quat mid_qq;
    logic           mid_sat;

    qrt_rot1 u_rot1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (in_ctl),
        .i_rot   (rot),
        .i_q2    (in_q2),
        .i_v     (in_v),
        .o_ctl   (mid_ctl),
        .o_r     (mid_r),
        .o_qq    (mid_qq),
        .o_sat   (mid_sat)
    );

    qrt_pkg::t_quat out_quat;
    qrt_pkg::t_vec  out_vec;

    qrt_rot2 u_rot2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mid_ctl),
        .i_rot   (rot),
        .i_shift (shift),
        .i_r     (mid_r),
        .i_qq    (mid_qq),
        .i_sat   (mid_sat),
        .o_valid (o_valid),
        .o_quat  (out_quat),
        .o_vec   (out_vec),
        .o_sat   (o_saturated)
    );

    assign o_out_qw = out_quat.w;
    assign o_out_qx = out_quat.x;
    assign o_out_qy = out_quat.y;
    assign o_out_qz = out_quat.z;
    assign o_out_x  = out_vec.x;
    assign o_out_y  = out_vec.y;
    assign o_out_z  = out_vec.z;

endmodule
